// ===== sv/sha256_pkg.sv =====
package sha256_pkg;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== sv/sha256_message_hasher.sv =====
// SHA-256 hasher. Takes a message byte in each transaction (has_byte qualifies data_byte,
// end_of_message closes the message, possibly with no byte) and returns eight digest
// words, word_index 0 first, last_word on the eighth. A byte that does not fill the
// block is simply stored. A byte that completes a 64-byte block runs the compression
// rounds in the single round unit (ST_ROUND), then ST_FOLD adds the result into the hash.
// End of message inserts padding and length one byte per cycle through the same path,
// pausing while a filled block is compressed, with up to two compressions, then the eight
// words, each held while out_stall is high. in_stall stays high throughout.
module sha256_message_hasher
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_FOLD  = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [31:0] hash_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [5:0]  pos_reg;
    logic [63:0] bits_reg, len_reg;
    logic [5:0]  round_reg;
    logic        pad_reg;
    logic [3:0]  pad_cnt_reg;
    logic [2:0]  out_idx_reg;
    logic        fin_reg;

    logic        put_en;
    logic [7:0]  put_byte;
    logic [31:0] big1, big0, ch, maj, t1, t2, s0, s1, w_new, wt;

    always_comb
    begin
        wt    = w_reg[0];
        big1  = ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1    = v_reg[7] + big1 + ch + ROUND_K[round_reg] + wt;
        big0  = ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2    = big0 + maj;
        s0    = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
    end

    // padding: 0x80, zeros until position 56, then length bytes
    always_comb
    begin
        put_en   = 1'b0;
        put_byte = 8'h00;
        if (state_reg == ST_IDLE && in_valid && has_byte)
        begin
            put_en   = 1'b1;
            put_byte = data_byte;
        end
        else if (state_reg == ST_PAD)
        begin
            put_en = 1'b1;
            if (!pad_reg)
                put_byte = PAD_BYTE;
            else if (pad_cnt_reg[3])
                put_byte = len_reg[63 - 8 * pad_cnt_reg[2:0] -: 8];
            else
                put_byte = 8'h00;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (has_byte && pos_reg == 6'd63)
                        state_next = ST_ROUND;
                    else if (end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_ROUND:
                if (round_reg == 6'd63)
                    state_next = ST_FOLD;
            ST_FOLD:
                state_next = fin_reg ? (pad_cnt_reg == 4'd15 ? ST_OUT : ST_PAD) : ST_IDLE;
            ST_PAD:
            begin
                if (pos_reg == 6'd63)
                    state_next = ST_ROUND;
            end
            ST_OUT:
                if (!out_stall && out_idx_reg == 3'd7)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            bits_reg    <= '0;
            round_reg   <= '0;
            pad_reg     <= 1'b0;
            pad_cnt_reg <= '0;
            out_idx_reg <= '0;
            fin_reg     <= 1'b0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= H_INIT[i];
        end
        else
        begin
            state_reg <= state_next;
            if (put_en)
            begin
                pos_reg <= pos_reg + 6'd1;
                w_reg[pos_reg[5:2]][8 * (3 - pos_reg[1:0]) +: 8] <= put_byte;
            end
            if (state_reg == ST_IDLE && in_valid)
            begin
                if (has_byte)
                    bits_reg <= bits_reg + 64'd8;
                if (end_of_message)
                begin
                    fin_reg     <= 1'b1;
                    pad_reg     <= 1'b0;
                    pad_cnt_reg <= '0;
                    len_reg     <= has_byte ? bits_reg + 64'd8 : bits_reg;
                end
            end
            if (state_reg == ST_PAD)
            begin
                pad_reg <= 1'b1;
                if (pad_cnt_reg[3])
                begin
                    if (pad_cnt_reg != 4'd15)
                        pad_cnt_reg <= pad_cnt_reg + 4'd1;
                end
                else if (pos_reg == 6'd55)
                    pad_cnt_reg <= 4'd8;
            end
            if (state_next == ST_ROUND && state_reg != ST_ROUND)
            begin
                round_reg <= '0;
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= hash_reg[i];
            end
            if (state_reg == ST_ROUND)
            begin
                round_reg <= round_reg + 6'd1;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= w_reg[i + 1];
                w_reg[15] <= w_new;
            end
            if (state_reg == ST_FOLD)
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
            if (state_reg == ST_OUT && !out_stall)
            begin
                out_idx_reg <= out_idx_reg + 3'd1;
                if (out_idx_reg == 3'd7)
                begin
                    fin_reg  <= 1'b0;
                    pos_reg  <= '0;
                    bits_reg <= '0;
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= H_INIT[i];
                end
            end
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign digest_word = hash_reg[out_idx_reg];
    assign word_index  = out_idx_reg;
    assign last_word   = (out_idx_reg == 3'd7);

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == 6'd63) |=> state_reg == ST_FOLD)
        else $error("compression did not end after 64 rounds");
    a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_idx_reg))
        else $error("digest index moved while stalled");
    a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !in_stall))
        else $error("input taken while digest pending");
    a_fold_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FOLD |=> state_reg != ST_FOLD)
        else $error("hash folded twice");

endmodule
